>>> sv/arlc_pkg.sv
// ----------------------------------------------------------------------------
// arlc_pkg: shared definitions for the array list with cursor
// Operation and status codes, default sizes, controller/datapath structs.
// ----------------------------------------------------------------------------
package arlc_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_FIRST  = 2'd1;
  localparam logic [1:0] OP_NEXT   = 2'd2;
  localparam logic [1:0] OP_REMOVE = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_FULL       = 2'd1;
  localparam logic [1:0] ST_NO_MORE    = 2'd2;
  localparam logic [1:0] ST_NO_CURRENT = 2'd3;

  typedef struct packed {
    logic accept;
    logic exec;
    logic capture;
    logic shift;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       fail;
    logic       more;
  } sts_t;

endpackage

>>> sv/arlc_ctrl.sv
// ----------------------------------------------------------------------------
// arlc_ctrl: sequencer for the array list with cursor
// Steps one item through execute, read capture and the remove shift loop,
// and owns the output valid flag.
// ----------------------------------------------------------------------------
module arlc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  arlc_pkg::sts_t sts,
  output arlc_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_CAP   = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid;
  logic       out_valid_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.fail || sts.op == arlc_pkg::OP_APPEND) begin
          state_next = S_LOAD;
        end else begin
          state_next = S_CAP;
        end
      end
      S_CAP: begin
        cmd.capture = 1'b1;
        if (sts.op == arlc_pkg::OP_REMOVE && sts.more) begin
          state_next = S_SHIFT;
        end else begin
          state_next = S_LOAD;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (!sts.more) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (!out_valid || m_tready) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign m_tvalid = out_valid;

endmodule

>>> sv/arlc_dpath.sv
// ----------------------------------------------------------------------------
// arlc_dpath: storage and datapath for the array list with cursor
// Element memory with registered read, count, cursor, shift index and the
// output register.
// ----------------------------------------------------------------------------
module arlc_dpath #(
  parameter int CAPACITY   = arlc_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = arlc_pkg::DATA_WIDTH_DEF,
  parameter int AW         = $clog2(CAPACITY),
  parameter int CW         = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  arlc_pkg::cmd_t        cmd,
  output arlc_pkg::sts_t        sts,
  input  logic [1:0]            in_op,
  input  logic [DATA_WIDTH-1:0] in_data,
  output logic [DATA_WIDTH-1:0] out_data,
  output logic [1:0]            out_status,
  output logic [CW-1:0]         out_count
);

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_data;
  logic [AW-1:0]         rd_addr;
  logic                  we;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;

  logic [1:0]            op;
  logic [DATA_WIDTH-1:0] data;
  logic [CW-1:0]         count;
  logic                  cur_valid;
  logic [AW-1:0]         cur_idx;
  logic [AW-1:0]         sh;
  logic [DATA_WIDTH-1:0] res_data;
  logic [1:0]            res_status;

  logic [CW-1:0]         next_pos;
  logic                  fail;
  logic [1:0]            fail_code;

  assign next_pos = cur_valid ? (CW'(cur_idx) + CW'(1)) : '0;

  always_comb begin
    fail      = 1'b0;
    fail_code = arlc_pkg::ST_OK;
    case (op)
      arlc_pkg::OP_APPEND: begin
        fail      = (count == CW'(CAPACITY));
        fail_code = arlc_pkg::ST_FULL;
      end
      arlc_pkg::OP_FIRST: begin
        fail      = (count == '0);
        fail_code = arlc_pkg::ST_NO_MORE;
      end
      arlc_pkg::OP_NEXT: begin
        fail      = (next_pos >= count);
        fail_code = arlc_pkg::ST_NO_MORE;
      end
      arlc_pkg::OP_REMOVE: begin
        fail      = !cur_valid || (CW'(cur_idx) >= count);
        fail_code = arlc_pkg::ST_NO_CURRENT;
      end
      default: begin
        fail      = 1'b0;
        fail_code = arlc_pkg::ST_OK;
      end
    endcase
  end

  assign sts.op   = op;
  assign sts.fail = fail;
  assign sts.more = (CW'(sh) + CW'(1)) < count;

  always_comb begin
    rd_addr = '0;
    if (cmd.exec) begin
      case (op)
        arlc_pkg::OP_NEXT:   rd_addr = next_pos[AW-1:0];
        arlc_pkg::OP_REMOVE: rd_addr = cur_idx;
        default:             rd_addr = '0;
      endcase
    end else if (cmd.capture) begin
      rd_addr = sh + AW'(1);
    end else if (cmd.shift) begin
      rd_addr = sh + AW'(2);
    end
  end

  always_comb begin
    we      = 1'b0;
    wr_addr = sh;
    wr_data = rd_data;
    if (cmd.exec && op == arlc_pkg::OP_APPEND && !fail) begin
      we      = 1'b1;
      wr_addr = count[AW-1:0];
      wr_data = data;
    end else if (cmd.shift) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op   <= in_op;
      data <= in_data;
    end
    if (cmd.exec) begin
      res_data   <= '0;
      res_status <= fail ? fail_code : arlc_pkg::ST_OK;
      sh         <= cur_idx;
    end
    if (cmd.capture) begin
      res_data <= rd_data;
    end
    if (cmd.shift) begin
      sh <= sh + AW'(1);
    end
    if (cmd.load) begin
      out_data   <= res_data;
      out_status <= res_status;
      out_count  <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cur_valid <= 1'b0;
      cur_idx   <= '0;
    end else begin
      if (cmd.exec && !fail) begin
        case (op)
          arlc_pkg::OP_APPEND: begin
            count <= count + CW'(1);
          end
          arlc_pkg::OP_FIRST: begin
            cur_valid <= 1'b1;
            cur_idx   <= '0;
          end
          arlc_pkg::OP_NEXT: begin
            cur_valid <= 1'b1;
            cur_idx   <= next_pos[AW-1:0];
          end
          default: begin
          end
        endcase
      end
      if (cmd.capture && op == arlc_pkg::OP_REMOVE) begin
        count <= count - CW'(1);
        if (cur_idx == '0) begin
          cur_valid <= 1'b0;
        end else begin
          cur_idx <= cur_idx - AW'(1);
        end
      end
    end
  end

endmodule

>>> sv/array_list_with_cursor_core.sv
// ----------------------------------------------------------------------------
// array_list_with_cursor_core: fixed-capacity list with a traversal cursor
// Append, go to first, go to next and remove current; one result per item.
// ----------------------------------------------------------------------------
// One item is taken at a time. Append and any failing operation go from accept
// through execute to the result register load; first and next add a read
// capture step, and remove adds to it a shift step per element shifted down
// (count - 1 - cursor, at most CAPACITY - 1), since the element memory has one
// write and one read port and the shift moves one element per cycle. A result
// waits in the output register while the next item is accepted; a finished
// item stalls only if that register is still occupied.
module array_list_with_cursor_core #(
  parameter int CAPACITY   = arlc_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = arlc_pkg::DATA_WIDTH_DEF,
  parameter int CW         = $clog2(CAPACITY + 1),
  parameter int IN_W       = ((DATA_WIDTH + 7) / 8) * 8,
  parameter int OUT_W      = ((DATA_WIDTH + CW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // item_data
  input  logic [1:0]       s_tuser,   // operation
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // result_data, element_count
  output logic [1:0]       m_tuser    // status
);

  arlc_pkg::cmd_t        cmd;
  arlc_pkg::sts_t        sts;
  logic [DATA_WIDTH-1:0] out_data;
  logic [CW-1:0]         out_count;

  arlc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  arlc_dpath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .CW         (CW)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (s_tuser),
    .in_data    (s_tdata[DATA_WIDTH-1:0]),
    .out_data   (out_data),
    .out_status (m_tuser),
    .out_count  (out_count)
  );

  assign m_tdata = OUT_W'({out_count, out_data});

endmodule
